FILE: design/ctt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_pkg
// Types and codes shared by the cooperative task timer table.
// ----------------------------------------------------------------------------
package ctt_pkg;

	localparam int SLOTW   = 4;
	localparam int TASKW   = 8;
	localparam int CNTW    = 16;
	localparam int SLOTINW = 3;
	localparam int STATW   = 2;

	typedef enum logic [1:0] {
		FUNC_TICK     = 2'd0,
		FUNC_ADD      = 2'd1,
		FUNC_DELETE   = 2'd2,
		FUNC_DISPATCH = 2'd3
	} func_t;

	typedef enum logic [STATW-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic             valid;
		logic [TASKW-1:0] task_id;
		logic [CNTW-1:0]  delay;
		logic [CNTW-1:0]  period;
		logic             run;
	} slot_rec_t;

endpackage

FILE: design/ctt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ctt_cell
// One task slot of the ring; takes its neighbor's record on each shift.
// ----------------------------------------------------------------------------
module ctt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               shift,
	input  ctt_pkg::slot_rec_t d,
	output ctt_pkg::slot_rec_t q
);

	ctt_pkg::slot_rec_t rec_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_q <= '0;
		end else if (shift) begin
			rec_q <= d;
		end
	end

	assign q = rec_q;

endmodule

FILE: design/cooperative_task_timer_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cooperative_task_timer_table
// Time-triggered cooperative task table built as a rotating ring of slots.
// ----------------------------------------------------------------------------
// Every input beat (tick, add, delete or dispatch) rotates the ring of
// MAX_TASKS slot cells once, one slot through the update logic at cell 0 per
// cycle, except that a step with a result ready waits while the output
// register still holds a beat that m_tready has not taken. A beat is taken
// only while the block is idle. The result of tick, add and delete, and of
// a dispatch with nothing due, is loaded in the final step; a dispatch emits
// one beat per due slot as that slot passes the head. A new beat is accepted
// once the rotation has finished.
module cooperative_task_timer_table #(
	parameter int MAX_TASKS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,  // task_ident, start_delay, period_in, slot_in
	input  logic [1:0]  s_tuser,  // func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // slot_out, task_out, status
	output logic [0:0]  m_tuser,  // due
	output logic        m_tlast
);

	localparam int IDXW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
	localparam int CMPW = (IDXW > ctt_pkg::SLOTINW) ? IDXW : ctt_pkg::SLOTINW;

	ctt_pkg::slot_rec_t cell_q [MAX_TASKS];
	ctt_pkg::slot_rec_t cell_d [MAX_TASKS];
	ctt_pkg::slot_rec_t rec_nx;
	ctt_pkg::slot_rec_t head;
	logic [MAX_TASKS-1:0] due_vec;

	logic                         busy_q;
	ctt_pkg::func_t               op_q;
	logic [ctt_pkg::TASKW-1:0]    ident_q;
	logic [ctt_pkg::CNTW-1:0]     sdelay_q;
	logic [ctt_pkg::CNTW-1:0]     period_q;
	logic [ctt_pkg::SLOTINW-1:0]  slot_in_q;
	logic [IDXW-1:0]              k_q;
	logic                         found_q;
	logic [ctt_pkg::SLOTW-1:0]    add_slot_q;
	logic                         emitted_q;

	logic                         m_valid_q;
	logic [ctt_pkg::SLOTW-1:0]    m_slot_q;
	logic [ctt_pkg::TASKW-1:0]    m_task_q;
	ctt_pkg::status_t             m_status_q;
	logic                         m_due_q;
	logic                         m_last_q;

	logic                         hit;
	logic                         last_step;
	logic                         later_due;
	logic                         emit;
	logic                         step;
	logic                         accept;
	logic [ctt_pkg::SLOTW-1:0]    r_slot;
	logic [ctt_pkg::TASKW-1:0]    r_task;
	ctt_pkg::status_t             r_status;
	logic                         r_due;
	logic                         r_last;

	// slot ring
	for (genvar i = 0; i < MAX_TASKS; i++) begin : g_cell
		if (i == MAX_TASKS - 1) begin : g_tail
			assign cell_d[i] = rec_nx;
		end else begin : g_mid
			assign cell_d[i] = cell_q[i+1];
		end
		assign due_vec[i] = cell_q[i].valid & cell_q[i].run;
		ctt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.shift  (step),
			.d      (cell_d[i]),
			.q      (cell_q[i])
		);
	end

	assign head      = cell_q[0];
	assign later_due = |(due_vec >> 1);
	assign last_step = (k_q == IDXW'(MAX_TASKS - 1));
	assign accept    = s_tvalid && s_tready;
	assign s_tready  = !busy_q;

	// update of the slot at the head of the ring
	always_comb begin
		rec_nx = head;
		hit    = 1'b0;
		case (op_q)
			ctt_pkg::FUNC_TICK: begin
				if (head.valid) begin
					if (head.delay == '0) begin
						rec_nx.run = 1'b1;
						if (head.period != '0) begin
							rec_nx.delay = head.period;
						end
					end else begin
						rec_nx.delay = head.delay - ctt_pkg::CNTW'(1);
					end
				end
			end
			ctt_pkg::FUNC_ADD: begin
				if (!found_q && !head.valid) begin
					rec_nx.valid   = 1'b1;
					rec_nx.task_id = ident_q;
					rec_nx.delay   = sdelay_q;
					rec_nx.period  = period_q;
					rec_nx.run     = 1'b0;
					hit            = 1'b1;
				end
			end
			ctt_pkg::FUNC_DELETE: begin
				if (head.valid && (CMPW'(slot_in_q) == CMPW'(k_q))) begin
					rec_nx = '0;
					hit    = 1'b1;
				end
			end
			ctt_pkg::FUNC_DISPATCH: begin
				if (head.valid && head.run) begin
					rec_nx.run = 1'b0;
					if (head.period == '0) begin
						rec_nx = '0;
					end
					hit = 1'b1;
				end
			end
			default: begin
				rec_nx = head;
			end
		endcase
	end

	// result of the current step
	always_comb begin
		r_slot   = '0;
		r_task   = '0;
		r_status = ctt_pkg::ST_OK;
		r_due    = 1'b0;
		r_last   = 1'b1;
		case (op_q)
			ctt_pkg::FUNC_ADD: begin
				if (found_q) begin
					r_slot = add_slot_q;
				end else if (hit) begin
					r_slot = ctt_pkg::SLOTW'(k_q);
				end else begin
					r_slot   = ctt_pkg::SLOTW'(MAX_TASKS);
					r_status = ctt_pkg::ST_FULL;
				end
			end
			ctt_pkg::FUNC_DELETE: begin
				r_slot = ctt_pkg::SLOTW'(slot_in_q);
				if (!(found_q || hit)) begin
					r_status = ctt_pkg::ST_EMPTY;
				end
			end
			ctt_pkg::FUNC_DISPATCH: begin
				if (hit) begin
					r_slot = ctt_pkg::SLOTW'(k_q);
					r_task = head.task_id;
					r_due  = 1'b1;
					r_last = !later_due;
				end
			end
			default: begin
				r_slot = '0;
			end
		endcase
	end

	always_comb begin
		if (op_q == ctt_pkg::FUNC_DISPATCH) begin
			emit = busy_q && (hit || (last_step && !emitted_q));
		end else begin
			emit = busy_q && last_step;
		end
		step = busy_q && (!emit || !m_valid_q || m_tready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			op_q       <= ctt_pkg::FUNC_TICK;
			k_q        <= '0;
			found_q    <= 1'b0;
			emitted_q  <= 1'b0;
			add_slot_q <= '0;
		end else if (accept) begin
			busy_q    <= 1'b1;
			op_q      <= ctt_pkg::func_t'(s_tuser);
			k_q       <= '0;
			found_q   <= 1'b0;
			emitted_q <= 1'b0;
		end else if (step) begin
			if (hit) begin
				found_q    <= 1'b1;
				emitted_q  <= 1'b1;
				add_slot_q <= ctt_pkg::SLOTW'(k_q);
			end
			if (last_step) begin
				busy_q <= 1'b0;
				k_q    <= '0;
			end else begin
				k_q <= k_q + IDXW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ident_q   <= s_tdata[7:0];
			sdelay_q  <= s_tdata[23:8];
			period_q  <= s_tdata[39:24];
			slot_in_q <= s_tdata[42:40];
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (step && emit) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			m_slot_q   <= r_slot;
			m_task_q   <= r_task;
			m_status_q <= r_status;
			m_due_q    <= r_due;
			m_last_q   <= r_last;
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = {2'b00, m_status_q, m_task_q, m_slot_q};
	assign m_tuser[0] = m_due_q;
	assign m_tlast    = m_last_q;

	a_idle_index: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (k_q == '0))
		else $error("ring index not at zero while idle");

	a_beat_from_walk: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(busy_q))
		else $error("result beat loaded outside a walk");

	a_hold_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_tready) |=>
			(m_valid_q && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast)))
		else $error("result beat changed while stalled");

	a_due_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_due_q) |-> (m_status_q == ctt_pkg::ST_OK))
		else $error("due beat with error status");

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the cooperative task timer table.
// ----------------------------------------------------------------------------
// Commands go in on the slave stream and result beats are checked on the
// master stream against a behavioral copy of the slot table. A directed
// opening covers empty and full tables, one-shot and periodic slots, field
// extremes and multi-beat dispatches. Random traffic follows in three
// phases with different backpressure on each side.
module tb;

	localparam int MAX_TASKS = 8;

	typedef struct packed {
		logic [ctt_pkg::SLOTW-1:0] slot;
		logic [ctt_pkg::TASKW-1:0] task_id;
		logic [ctt_pkg::STATW-1:0] status;
		logic                      due;
		logic                      last;
	} beat_t;

	class task_table_model;
		logic                      used[MAX_TASKS];
		logic [ctt_pkg::TASKW-1:0] ident[MAX_TASKS];
		logic [ctt_pkg::CNTW-1:0]  delay[MAX_TASKS];
		logic [ctt_pkg::CNTW-1:0]  period[MAX_TASKS];
		logic                      run[MAX_TASKS];
		beat_t                     result_fifo[$];
		int                        errors;

		function new();
			errors = 0;
			for (int i = 0; i < MAX_TASKS; i++)
				free_slot(i);
		endfunction

		function void free_slot(int i);
			used[i]   = 1'b0;
			ident[i]  = '0;
			delay[i]  = '0;
			period[i] = '0;
			run[i]    = 1'b0;
		endfunction

		function beat_t make_beat(int slot, logic [ctt_pkg::TASKW-1:0] tid,
				ctt_pkg::status_t st, logic due, logic last);
			beat_t b;
			b.slot    = ctt_pkg::SLOTW'(slot);
			b.task_id = tid;
			b.status  = st;
			b.due     = due;
			b.last    = last;
			return b;
		endfunction

		function void apply_command(ctt_pkg::func_t fn, logic [ctt_pkg::TASKW-1:0] tid,
				logic [ctt_pkg::CNTW-1:0] sdelay, logic [ctt_pkg::CNTW-1:0] per,
				logic [ctt_pkg::SLOTINW-1:0] sidx);
			int n;
			int found;
			n = 0;
			found = -1;
			case (fn)
				ctt_pkg::FUNC_TICK: begin
					for (int i = 0; i < MAX_TASKS; i++) begin
						if (!used[i])
							continue;
						if (delay[i] == 0) begin
							run[i] = 1'b1;
							if (period[i] != 0)
								delay[i] = period[i];
						end else begin
							delay[i] = delay[i] - 1'b1;
						end
					end
					result_fifo.push_back(make_beat(0, '0, ctt_pkg::ST_OK, 1'b0, 1'b1));
				end
				ctt_pkg::FUNC_ADD: begin
					for (int i = 0; i < MAX_TASKS; i++)
						if (!used[i] && found < 0)
							found = i;
					if (found < 0) begin
						result_fifo.push_back(make_beat(MAX_TASKS, '0, ctt_pkg::ST_FULL,
							1'b0, 1'b1));
					end else begin
						used[found]   = 1'b1;
						ident[found]  = tid;
						delay[found]  = sdelay;
						period[found] = per;
						run[found]    = 1'b0;
						result_fifo.push_back(make_beat(found, '0, ctt_pkg::ST_OK,
							1'b0, 1'b1));
					end
				end
				ctt_pkg::FUNC_DELETE: begin
					if (sidx < MAX_TASKS && used[sidx]) begin
						free_slot(sidx);
						result_fifo.push_back(make_beat(sidx, '0, ctt_pkg::ST_OK,
							1'b0, 1'b1));
					end else begin
						result_fifo.push_back(make_beat(sidx, '0, ctt_pkg::ST_EMPTY,
							1'b0, 1'b1));
					end
				end
				default: begin
					for (int i = 0; i < MAX_TASKS; i++) begin
						if (!(used[i] && run[i]))
							continue;
						result_fifo.push_back(make_beat(i, ident[i], ctt_pkg::ST_OK,
							1'b1, 1'b0));
						n++;
						run[i] = 1'b0;
						if (period[i] == 0)
							free_slot(i);
					end
					if (n == 0)
						result_fifo.push_back(make_beat(0, '0, ctt_pkg::ST_OK, 1'b0, 1'b1));
					else
						result_fifo[result_fifo.size()-1].last = 1'b1;
				end
			endcase
		endfunction

		function void report(string field, logic [15:0] exp_v, logic [15:0] act_v);
			errors++;
			$display("%0t: %s expected %0h actual %0h", $time, field, exp_v, act_v);
		endfunction

		function void compare_beat(beat_t got);
			beat_t exp_b;
			if (result_fifo.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat expected none actual %0h", $time, got);
				return;
			end
			exp_b = result_fifo.pop_front();
			if (got.slot !== exp_b.slot)
				report("slot_out", 16'(exp_b.slot), 16'(got.slot));
			if (got.task_id !== exp_b.task_id)
				report("task_out", 16'(exp_b.task_id), 16'(got.task_id));
			if (got.status !== exp_b.status)
				report("status", 16'(exp_b.status), 16'(got.status));
			if (got.due !== exp_b.due)
				report("due", 16'(exp_b.due), 16'(got.due));
			if (got.last !== exp_b.last)
				report("last", 16'(exp_b.last), 16'(got.last));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata = '0;   // task_ident, start_delay, period_in, slot_in
	logic [1:0]  s_tuser = '0;   // func
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // slot_out, task_out, status
	logic [0:0]  m_tuser;        // due
	logic        m_tlast;

	int tx_idle_pct = 13;
	int rx_idle_pct = 71;

	task_table_model table_model = new();

	cooperative_task_timer_table #(.MAX_TASKS(MAX_TASKS)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= rx_idle_pct);
	end

	always @(posedge clk) begin
		beat_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.slot    = m_tdata[3:0];
			got.task_id = m_tdata[11:4];
			got.status  = m_tdata[13:12];
			got.due     = m_tuser[0];
			got.last    = m_tlast;
			table_model.compare_beat(got);
		end
	end

	task automatic send_cmd(ctt_pkg::func_t fn, logic [ctt_pkg::TASKW-1:0] tid,
			logic [ctt_pkg::CNTW-1:0] sdelay, logic [ctt_pkg::CNTW-1:0] per,
			logic [ctt_pkg::SLOTINW-1:0] sidx);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= fn;
		s_tdata  <= {5'b0, sidx, per, sdelay, tid};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		table_model.apply_command(fn, tid, sdelay, per, sidx);
	endtask

	task automatic send_random_cmd();
		int                       pick;
		ctt_pkg::func_t           fn;
		logic [ctt_pkg::CNTW-1:0] sdelay;
		logic [ctt_pkg::CNTW-1:0] per;
		pick = $urandom_range(99);
		if (pick < 35)
			fn = ctt_pkg::FUNC_TICK;
		else if (pick < 60)
			fn = ctt_pkg::FUNC_ADD;
		else if (pick < 75)
			fn = ctt_pkg::FUNC_DELETE;
		else
			fn = ctt_pkg::FUNC_DISPATCH;
		// short delays and periods keep slots cycling through due
		sdelay = ($urandom_range(99) < 80) ? ctt_pkg::CNTW'($urandom_range(4))
			: ctt_pkg::CNTW'($urandom_range(65535));
		pick = $urandom_range(99);
		if (pick < 30)
			per = '0;
		else if (pick < 85)
			per = ctt_pkg::CNTW'($urandom_range(5, 1));
		else
			per = ctt_pkg::CNTW'($urandom_range(65535));
		send_cmd(fn, ctt_pkg::TASKW'($urandom_range(255)), sdelay, per,
			ctt_pkg::SLOTINW'($urandom_range(7)));
	endtask

	initial begin
		#100_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_cmd(ctt_pkg::FUNC_TICK, 8'h00, 16'h0000, 16'h0000, 3'd0);
		send_cmd(ctt_pkg::FUNC_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0);
		send_cmd(ctt_pkg::FUNC_DELETE, 8'h00, 16'h0000, 16'h0000, 3'd3);
		send_cmd(ctt_pkg::FUNC_ADD, 8'hff, 16'h0000, 16'h0000, 3'd7);
		send_cmd(ctt_pkg::FUNC_ADD, 8'h00, 16'hffff, 16'hffff, 3'd0);
		send_cmd(ctt_pkg::FUNC_ADD, 8'ha5, 16'h0001, 16'h0002, 3'd0);
		send_cmd(ctt_pkg::FUNC_ADD, 8'h5a, 16'h0000, 16'h0001, 3'd0);
		send_cmd(ctt_pkg::FUNC_ADD, 8'h3c, 16'h0000, 16'hffff, 3'd0);
		send_cmd(ctt_pkg::FUNC_ADD, 8'hc3, 16'h0002, 16'h0000, 3'd0);
		send_cmd(ctt_pkg::FUNC_ADD, 8'h81, 16'h0001, 16'h0001, 3'd0);
		send_cmd(ctt_pkg::FUNC_ADD, 8'h7e, 16'h0000, 16'h0003, 3'd0);
		send_cmd(ctt_pkg::FUNC_ADD, 8'h11, 16'h0005, 16'h0005, 3'd0);
		send_cmd(ctt_pkg::FUNC_TICK, 8'h00, 16'h0000, 16'h0000, 3'd0);
		// undispatched one-shot keeps zero delay and is flagged again
		send_cmd(ctt_pkg::FUNC_TICK, 8'h00, 16'h0000, 16'h0000, 3'd0);
		send_cmd(ctt_pkg::FUNC_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0);
		send_cmd(ctt_pkg::FUNC_DELETE, 8'h00, 16'h0000, 16'h0000, 3'd1);
		send_cmd(ctt_pkg::FUNC_DELETE, 8'h00, 16'h0000, 16'h0000, 3'd1);
		send_cmd(ctt_pkg::FUNC_ADD, 8'h42, 16'h0000, 16'h0000, 3'd0);
		send_cmd(ctt_pkg::FUNC_TICK, 8'h00, 16'h0000, 16'h0000, 3'd0);
		send_cmd(ctt_pkg::FUNC_TICK, 8'h00, 16'h0000, 16'h0000, 3'd0);
		send_cmd(ctt_pkg::FUNC_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0);
		send_cmd(ctt_pkg::FUNC_DELETE, 8'h00, 16'h0000, 16'h0000, 3'd7);
		send_cmd(ctt_pkg::FUNC_DISPATCH, 8'h00, 16'h0000, 16'h0000, 3'd0);

		repeat (146) send_random_cmd();
		tx_idle_pct = 71;
		rx_idle_pct = 13;
		repeat (146) send_random_cmd();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		repeat (145) send_random_cmd();

		s_tvalid <= 1'b0;
		while (table_model.result_fifo.size() != 0)
			@(posedge clk);
		repeat (4 * MAX_TASKS) @(posedge clk);

		if (table_model.errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

FILE: filelist.f
design/ctt_pkg.sv
design/ctt_cell.sv
design/cooperative_task_timer_table.sv
bench/tb.sv
